// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  `ASSERT_AT(lbl, ck, rs, (ante) |-> (cons), msg)
`else
`define ASSERT_AT(lbl, ck, rs, prop, msg)
`define ASSERT_IMPL(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// ===== hdl/gsr_pkg.sv =====
package gsr_pkg;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 64;
  localparam int STEP_W      = 16;
  localparam int CNT_REG_W   = 8;
  localparam int CELL_W      = 48;
  localparam int IDX_W       = 7;
  localparam int VAL_W       = 32;
  localparam int CFG_IDX_W   = 2;

  // quotient bits of every division; the rounded shift stays below 2^17
  localparam int QW  = 17;
  localparam int DCW = $clog2(QW);

  localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SLOTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_HOP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP = 2'd3;

  localparam logic signed [CELL_W-1:0] CELL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [CELL_W-1:0] CELL_MIN = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_DIV, ST_POST, ST_PREP, ST_READ, ST_WAIT, ST_WRITE
  } state_t;

  typedef enum logic [2:0] {
    OP_BMOD, OP_SMOD, OP_FDIV, OP_FMOD, OP_TDIV, OP_TMOD
  } op_t;

endpackage

// ===== hdl/gabor_spectrogram_reassign.sv =====
// Channel   | Dir | Contents
// s_axis    | in  | tuser: kind; tdata: bin, slot, energy, freq grad, time grad
// m_axis    | out | tuser: saturated; tdata: target bin, target slot, cell value
// cfg       | in  | write enable, register index, 16-bit data
//
// One item at a time through a shared 17-step restoring divider.
// A read item runs two index reductions; an accumulate item runs two index
// reductions, two rounded divisions and two wraps, all on the shared divider.
// After reset a clearing pass zeroes all MAX_BINS*MAX_SLOTS cells of the plane.
// A held result does not block the next transfer; the write-back waits for it.
`include "assert_macros.svh"
module gabor_spectrogram_reassign #(
  parameter int MAX_BINS  = 128,
  parameter int MAX_SLOTS = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // bin_index, slot_index, energy, freq_shift_grad, time_shift_grad
  input  logic [gsr_pkg::IN_TDATA_W-1:0]       s_tdata,
  // kind
  input  logic [0:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // target_bin, target_slot, cell_value
  output logic [gsr_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // saturated
  output logic [0:0]                           m_tuser,
  input  logic                                 cfg_we,
  input  logic [gsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gsr_pkg::STEP_W-1:0]           cfg_data
);
  import gsr_pkg::*;

  localparam int MAXC  = (MAX_BINS > MAX_SLOTS) ? MAX_BINS : MAX_SLOTS;
  localparam int CW    = $clog2(MAXC + 1);
  localparam int DVW   = (CW > STEP_W) ? CW : STEP_W;
  localparam int NW    = CW + 35;
  localparam int DDW   = NW + 1 - 17;
  localparam int DEPTH = MAX_BINS * MAX_SLOTS;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic [CNT_REG_W-1:0] num_bins, num_slots;
  logic [STEP_W-1:0]    time_hop, freq_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins  <= 8'd128;
      num_slots <= 8'd128;
      time_hop  <= 16'd1;
      freq_step <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_BINS:  num_bins  <= cfg_data[CNT_REG_W-1:0];
        REG_NUM_SLOTS: num_slots <= cfg_data[CNT_REG_W-1:0];
        REG_TIME_HOP:  time_hop  <= cfg_data;
        REG_FREQ_STEP: freq_step <= cfg_data;
      endcase
    end
  end

  logic [CW-1:0]     nb_c, ns_c;
  logic [STEP_W-1:0] fst_c, tst_c;

  always_comb begin
    if (num_bins == '0) nb_c = CW'(1);
    else if (32'(num_bins) > MAX_BINS) nb_c = CW'(MAX_BINS);
    else nb_c = CW'(num_bins);
    if (num_slots == '0) ns_c = CW'(1);
    else if (32'(num_slots) > MAX_SLOTS) ns_c = CW'(MAX_SLOTS);
    else ns_c = CW'(num_slots);
    fst_c = (freq_step == '0) ? STEP_W'(1) : freq_step;
    tst_c = (time_hop == '0) ? STEP_W'(1) : time_hop;
  end

  // sequencer
  state_t state, state_next;
  op_t    op, op_next;
  logic [DCW-1:0] div_cnt;
  logic [AW-1:0]  clr;

  // item and datapath registers
  logic                    kind;
  logic [IDX_W-1:0]        bin_in, slot_in;
  logic signed [VAL_W-1:0] energy, fgrad, tgrad;
  logic [CW-1:0]           nb, ns, bin_r, slot_r;
  logic [STEP_W-1:0]       fst, tst;
  logic signed [NW-1:0]    num;
  logic                    qneg;
  logic [DVW-1:0]          rem, dv;
  logic [QW-1:0]           quo;
  logic [AW-1:0]           addr;
  logic [CELL_W-1:0]       mem_q;

  logic                    out_valid, out_sat;
  logic [CW-1:0]           out_bin, out_slot;
  logic signed [CELL_W-1:0] out_cell;

  logic mem_we, out_load;

  always_comb begin
    state_next = state;
    op_next    = op;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_LOAD;
          op_next    = OP_BMOD;
        end
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DCW'(QW - 1)) state_next = ST_POST;
      end
      ST_PREP: state_next = ST_LOAD;
      ST_POST: begin
        unique case (op)
          OP_BMOD: begin
            op_next = OP_SMOD;
            state_next = ST_LOAD;
          end
          OP_SMOD: begin
            if (kind) state_next = ST_READ;
            else begin
              op_next = OP_FDIV;
              state_next = ST_PREP;
            end
          end
          OP_FDIV: begin
            op_next = OP_FMOD;
            state_next = ST_LOAD;
          end
          OP_FMOD: begin
            op_next = OP_TDIV;
            state_next = ST_PREP;
          end
          OP_TDIV: begin
            op_next = OP_TMOD;
            state_next = ST_LOAD;
          end
          OP_TMOD: state_next = ST_READ;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_READ: state_next = ST_WAIT;
      ST_WAIT: state_next = ST_WRITE;
      ST_WRITE: begin
        // hold the write-back until the previous result is taken
        if (!out_valid || m_tready) begin
          mem_we     = 1'b1;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      op      <= OP_BMOD;
      clr     <= '0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (state == ST_CLEAR) clr <= clr + AW'(1);
      if (state == ST_DIV) div_cnt <= div_cnt + DCW'(1);
      else div_cnt <= '0;
    end
  end

  // per-axis operand selection
  logic                     fax;
  logic [CW-1:0]            idx_sel, cnt_sel;
  logic [STEP_W-1:0]        st_sel;
  logic signed [VAL_W-1:0]  grad_sel;
  logic signed [CW:0]       k_c;
  logic signed [CW+17:0]    prod_c;
  logic signed [NW-1:0]     num_c;
  logic [NW-1:0]            mag_c;
  logic [NW:0]              rnd_c;
  logic [DDW-1:0]           dd_c;
  logic [DVW-1:0]           dv_c;
  logic [DVW:0]             trial;
  logic                     ge;
  logic [CW-1:0]            wrap_c;

  always_comb begin
    fax      = (op == OP_FDIV) || (op == OP_FMOD) || (op == OP_BMOD);
    idx_sel  = fax ? bin_r : slot_r;
    cnt_sel  = fax ? nb : ns;
    st_sel   = fax ? fst : tst;
    grad_sel = fax ? fgrad : tgrad;
    // signed FFT index: upper half maps below zero
    if (idx_sel <= (cnt_sel >> 1)) k_c = $signed({1'b0, idx_sel});
    else k_c = $signed({1'b0, idx_sel}) - $signed({1'b0, cnt_sel});
    prod_c = k_c * $signed({1'b0, st_sel});
    num_c  = NW'(grad_sel) + (NW'(prod_c) <<< 16);
    mag_c  = num[NW-1] ? NW'(-num) : NW'(num);
    // round half away from zero: (2|num| + den) / (2 den), den = step << 16
    rnd_c  = {mag_c, 1'b0} + ((NW + 1)'(st_sel) << 16);
    unique case (op)
      OP_BMOD: begin
        dd_c = DDW'(bin_in);
        dv_c = DVW'(nb);
      end
      OP_SMOD: begin
        dd_c = DDW'(slot_in);
        dv_c = DVW'(ns);
      end
      OP_FDIV, OP_TDIV: begin
        dd_c = rnd_c[NW:17];
        dv_c = DVW'(st_sel);
      end
      OP_FMOD, OP_TMOD: begin
        dd_c = DDW'(quo);
        dv_c = DVW'(cnt_sel);
      end
      default: begin
        dd_c = '0;
        dv_c = DVW'(1);
      end
    endcase
    trial  = {rem, quo[QW-1]};
    ge     = trial >= {1'b0, dv};
    wrap_c = (qneg && rem != '0) ? cnt_sel - CW'(rem) : CW'(rem);
  end

  logic signed [CELL_W:0]   sum_c;
  logic signed [CELL_W-1:0] sat_val;
  logic                     sat_c;
  logic [AW-1:0]            addr_c;

  always_comb begin
    sum_c   = (CELL_W + 1)'($signed(mem_q)) + (CELL_W + 1)'(energy);
    sat_c   = sum_c[CELL_W] != sum_c[CELL_W-1];
    sat_val = sat_c ? (sum_c[CELL_W] ? CELL_MIN : CELL_MAX) : sum_c[CELL_W-1:0];
    addr_c  = AW'(32'(bin_r) + 32'(slot_r) * MAX_BINS);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          kind    <= s_tuser[0];
          bin_in  <= s_tdata[6:0];
          slot_in <= s_tdata[13:7];
          energy  <= s_tdata[45:14];
          fgrad   <= s_tdata[77:46];
          tgrad   <= s_tdata[109:78];
          nb      <= nb_c;
          ns      <= ns_c;
          fst     <= fst_c;
          tst     <= tst_c;
        end
      end
      ST_PREP: num <= num_c;
      ST_LOAD: begin
        rem <= DVW'(dd_c >> QW);
        quo <= dd_c[QW-1:0];
        dv  <= dv_c;
        if (op == OP_FDIV || op == OP_TDIV) qneg <= num[NW-1];
        else if (op == OP_BMOD) qneg <= 1'b0;
      end
      ST_DIV: begin
        rem <= ge ? DVW'(trial - {1'b0, dv}) : trial[DVW-1:0];
        quo <= {quo[QW-2:0], ge};
      end
      ST_POST: begin
        unique case (op)
          OP_BMOD: bin_r  <= CW'(rem);
          OP_SMOD: slot_r <= CW'(rem);
          OP_FMOD: bin_r  <= wrap_c;
          OP_TMOD: slot_r <= wrap_c;
          default: ;
        endcase
      end
      ST_READ: addr <= addr_c;
      default: ;
    endcase
  end

  // plane store
  logic [CELL_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wa;
  logic [CELL_W-1:0] wd;

  always_comb begin
    wa = (state == ST_CLEAR) ? clr : addr;
    wd = (state == ST_CLEAR || kind) ? '0 : sat_val;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wa] <= wd;
    mem_q <= mem[addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (m_tready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin  <= bin_r;
      out_slot <= slot_r;
      out_cell <= kind ? $signed(mem_q) : sat_val;
      out_sat  <= kind ? 1'b0 : sat_c;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_cell, IDX_W'(out_slot), IDX_W'(out_bin)};
  assign m_tuser  = out_sat;

  `ASSERT_IMPL(a_rem_below_divisor, clk, rst, state == ST_DIV, rem < dv, "remainder not below divisor")
  `ASSERT_AT(a_hold_writeback, clk, rst, (state == ST_WRITE && out_valid && !m_tready) |=> (state == ST_WRITE), "write-back passed a held result")
  `ASSERT_AT(a_busy_after_transfer, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "ready after a transfer")
  `ASSERT_IMPL(a_sat_at_limit, clk, rst, out_valid && out_sat, out_cell == CELL_MAX || out_cell == CELL_MIN, "saturated flag without limit value")

endmodule
